// ===== rtl/marker_word_rle_decoder_defines.svh =====
// Assertion macros for the marker-word run-length decoder.
// Included by the top level; needs no other file.
`ifndef MARKER_WORD_RLE_DECODER_DEFINES_SVH
`define MARKER_WORD_RLE_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MWRLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mwrle: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define MWRLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mwrle: next-cycle check failed");

`endif

// ===== rtl/mwrle_pkg.sv =====
// Shared types and constants for the marker-word run-length decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mwrle_pkg;

  // Field widths
  localparam int unsigned WordW = 16;
  localparam int unsigned LenW  = 17;

  // Markers and fill words
  localparam logic [WordW-1:0] ZeroMark = 16'h1234;
  localparam logic [WordW-1:0] FillMark = 16'h5678;
  localparam logic [WordW-1:0] ZeroFill = 16'h0000;
  localparam logic [WordW-1:0] OnesFill = 16'hFFFF;

  // Result queue depth default (must be at least 2)
  localparam int unsigned DefFifoDepth = 4;

  // Decode phase codes
  localparam int unsigned PhaseW = 2;
  localparam logic [PhaseW-1:0] PhIdle = 2'd0;  // at a marker position
  localparam logic [PhaseW-1:0] PhZcnt = 2'd1;  // zero marker seen
  localparam logic [PhaseW-1:0] PhFcnt = 2'd2;  // fill marker seen
  localparam logic [PhaseW-1:0] PhZz   = 2'd3;  // zero marker, count equal to marker

  // One run descriptor
  typedef struct packed {
    logic [WordW-1:0] value;
    logic [LenW-1:0]  length;
    logic             stream_end;
  } run_t;

  // Results of one decoded word, pushed into the queue together
  typedef struct packed {
    logic [1:0] count;
    run_t       first;
    run_t       second;
  } push_t;

  // Run length from a count word: count + 1
  function automatic logic [LenW-1:0] count_len(input logic [WordW-1:0] w);
    return {1'b0, w} + LenW'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/marker_word_rle_decoder.sv =====
// Marker-word run-length decoder, top level.
// Depends on mwrle_pkg, mwrle_decode, mwrle_fifo and marker_word_rle_decoder_defines.svh.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / code_word_i) takes one 16-bit
//   compressed word per transaction. Output channel (out_valid_o / out_ready_i)
//   gives run descriptors: run_value_o repeated run_length_o times, or an end
//   item with stream_end_o set and length zero.
//   An accepted word goes into the input register, is decoded there, and its
//   results are written into the result queue. Throughput: one word per cycle
//   while the queue has room. A word may yield two results; the result queue
//   (FifoDepth entries) drains one per cycle while the receiver is ready.
//   Two-result words are at least three words apart, so with a ready receiver
//   and at least four queue entries the input never stalls. The decode stage
//   moves a word on only when the queue has room for two results.
//   Reset: clears the decode phase to idle and empties the input register and
//   the result queue; no clearing pass is needed.
//   Receiver stall: results wait in the queue, and once it lacks room for two
//   more the input register holds and in_ready_o drops.
`timescale 1ns / 1ps
`default_nettype none
`include "marker_word_rle_decoder_defines.svh"

module marker_word_rle_decoder import mwrle_pkg::*; #(
  parameter int unsigned FifoDepth = DefFifoDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [WordW-1:0]  code_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [WordW-1:0]       run_value_o,
  output logic [LenW-1:0]        run_length_o,
  output logic                   stream_end_o
);

  push_t             push;
  logic              room;
  logic [PhaseW-1:0] phase;
  run_t              out_run;

  // Input register and decode
  mwrle_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .code_word_i (code_word_i),
    .room_i      (room),
    .push_o      (push),
    .phase_o     (phase)
  );

  // Result queue
  mwrle_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_run_o   (out_run)
  );

  assign run_value_o  = out_run.value;
  assign run_length_o = out_run.length;
  assign stream_end_o = out_run.stream_end;

  // End items carry no run; ordinary runs are never empty
  `MWRLE_ASSERT_IMP(a_end_empty, clk_i, rst_ni, out_valid_o && stream_end_o, run_length_o == '0)
  `MWRLE_ASSERT_IMP(a_run_nonzero, clk_i, rst_ni, out_valid_o && !stream_end_o, run_length_o != '0)
  // After an end item is decoded the phase is back at idle
  `MWRLE_ASSERT_NXT(a_end_idle, clk_i, rst_ni, push.count != 2'd0 && push.first.stream_end, phase == PhIdle)
  // Two results only come from the pending zero-run phase
  `MWRLE_ASSERT_IMP(a_two_from_zz, clk_i, rst_ni, push.count == 2'd2, phase == PhZz)

endmodule

`default_nettype wire

// ===== rtl/mwrle_decode.sv =====
// Input register, decode phase register and the per-word decode logic.
// Depends on mwrle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mwrle_decode import mwrle_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [WordW-1:0]  code_word_i,
  input  wire logic              room_i,
  output push_t                  push_o,
  output logic [PhaseW-1:0]      phase_o
);

  logic              valid_q, valid_d;
  logic [WordW-1:0]  word_q;
  logic [PhaseW-1:0] phase_q, phase_d, phase_n;
  logic              advance;
  logic [1:0]        n_res;
  run_t              r0, r1;

  // Word in the input register moves on when the queue has room for two results
  assign advance    = valid_q && room_i;
  assign in_ready_o = !valid_q || advance;

  always_comb begin
    valid_d = valid_q;
    if (advance) valid_d = 1'b0;
    if (in_valid_i && in_ready_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= PhIdle;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) word_q <= code_word_i;
  end

  // Decode one word against the current phase
  always_comb begin
    n_res   = 2'd0;
    phase_n = PhIdle;
    r0      = '{value: ZeroFill, length: '0, stream_end: 1'b0};
    r1      = '{value: ZeroFill, length: '0, stream_end: 1'b0};
    unique case (phase_q)
      PhZcnt: begin
        if (word_q == ZeroMark) begin
          phase_n = PhZz;
        end else begin
          n_res = 2'd1;
          if (word_q == ZeroFill) r0 = '{value: ZeroMark, length: LenW'(1), stream_end: 1'b0};
          else r0 = '{value: ZeroFill, length: count_len(word_q), stream_end: 1'b0};
        end
      end
      PhFcnt: begin
        n_res = 2'd1;
        if (word_q == ZeroFill) r0 = '{value: FillMark, length: LenW'(1), stream_end: 1'b0};
        else r0 = '{value: OnesFill, length: count_len(word_q), stream_end: 1'b0};
      end
      PhZz: begin
        n_res = 2'd1;
        if (word_q == ZeroMark) begin
          // end of stream
          r0 = '{value: ZeroFill, length: '0, stream_end: 1'b1};
        end else begin
          // pending zero run of marker+1 words, then the word from idle
          r0 = '{value: ZeroFill, length: count_len(ZeroMark), stream_end: 1'b0};
          if (word_q == ZeroMark) phase_n = PhZcnt;
          else if (word_q == FillMark) phase_n = PhFcnt;
          else begin
            n_res = 2'd2;
            r1    = '{value: word_q, length: LenW'(1), stream_end: 1'b0};
          end
        end
      end
      default: begin
        if (word_q == ZeroMark) phase_n = PhZcnt;
        else if (word_q == FillMark) phase_n = PhFcnt;
        else begin
          n_res = 2'd1;
          r0    = '{value: word_q, length: LenW'(1), stream_end: 1'b0};
        end
      end
    endcase
  end

  assign phase_d       = advance ? phase_n : phase_q;
  assign push_o.count  = advance ? n_res : 2'd0;
  assign push_o.first  = r0;
  assign push_o.second = r1;
  assign phase_o       = phase_q;

endmodule

`default_nettype wire

// ===== rtl/mwrle_fifo.sv =====
// Result queue: takes up to two run descriptors per cycle, gives one per transaction.
// Depends on mwrle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mwrle_fifo import mwrle_pkg::*; #(
  parameter int unsigned Depth = DefFifoDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output run_t       out_run_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  run_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_nxt;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_nxt      = ptr_inc(wr_ptr_q);
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (count_q <= CntW'(Depth - 2));
  assign out_run_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    unique case (push_i.count)
      2'd0:    wr_ptr_d = wr_ptr_q;
      2'd1:    wr_ptr_d = wr_nxt;
      default: wr_ptr_d = ptr_inc(wr_nxt);
    endcase
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wr_nxt]   <= push_i.second;
  end

endmodule

`default_nettype wire

// ===== test/mwrle_run_checker.sv =====
// Run descriptor checker for the marker-word run-length decoder testbench.
// Watches both channels, predicts run descriptors and compares them in order.
// Depends on mwrle_pkg.
`timescale 1ns / 1ps

module mwrle_run_checker import mwrle_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_ready_i,
  input  wire logic [WordW-1:0] code_word_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_ready_i,
  input  wire logic [WordW-1:0] run_value_i,
  input  wire logic [LenW-1:0]  run_length_i,
  input  wire logic             stream_end_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int ReportMax = 10;

  logic [PhaseW-1:0] decode_phase_q;
  run_t              expected_runs[$];
  run_t              oldest_run;

  function automatic run_t make_run(input logic [WordW-1:0] value,
                                    input logic [LenW-1:0] length,
                                    input logic fin);
    run_t r;
    r.value      = value;
    r.length     = length;
    r.stream_end = fin;
    return r;
  endfunction

  // Word at a marker position: literal, or start of a marker pair
  task automatic decode_at_marker_pos(input logic [WordW-1:0] w);
    if (w == ZeroMark) begin
      decode_phase_q = PhZcnt;
    end else if (w == FillMark) begin
      decode_phase_q = PhFcnt;
    end else begin
      decode_phase_q = PhIdle;
      expected_runs.push_back(make_run(w, LenW'(1), 1'b0));
    end
  endtask

  // Expected run descriptors for one accepted code word
  task automatic predict_runs(input logic [WordW-1:0] w);
    case (decode_phase_q)
      PhZcnt: begin
        if (w == ZeroMark) begin
          decode_phase_q = PhZz;
        end else begin
          decode_phase_q = PhIdle;
          if (w == '0) expected_runs.push_back(make_run(ZeroMark, LenW'(1), 1'b0));
          else expected_runs.push_back(make_run(ZeroFill, LenW'(w) + LenW'(1), 1'b0));
        end
      end
      PhFcnt: begin
        // any word is a count here, markers included
        decode_phase_q = PhIdle;
        if (w == '0) expected_runs.push_back(make_run(FillMark, LenW'(1), 1'b0));
        else expected_runs.push_back(make_run(OnesFill, LenW'(w) + LenW'(1), 1'b0));
      end
      PhZz: begin
        if (w == ZeroMark) begin
          // third zero marker: end of stream
          decode_phase_q = PhIdle;
          expected_runs.push_back(make_run(ZeroFill, '0, 1'b1));
        end else begin
          // pending zero run, then the word decodes from idle
          expected_runs.push_back(make_run(ZeroFill, LenW'(ZeroMark) + LenW'(1), 1'b0));
          decode_at_marker_pos(w);
        end
      end
      default: decode_at_marker_pos(w);
    endcase
  endtask

  // Predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_phase_q = PhIdle;
      expected_runs.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_runs(code_word_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_runs.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportMax)
            $display("%0t: unexpected run: value %h length %0d end %0b",
                     $realtime, run_value_i, run_length_i, stream_end_i);
        end else begin
          oldest_run = expected_runs.pop_front();
          if (oldest_run.value !== run_value_i || oldest_run.length !== run_length_i ||
              oldest_run.stream_end !== stream_end_i) begin
            fail_count_o++;
            if (fail_count_o <= ReportMax)
              $display("%0t: run mismatch: expected value %h length %0d end %0b, got %h %0d %0b",
                       $realtime, oldest_run.value, oldest_run.length,
                       oldest_run.stream_end, run_value_i, run_length_i, stream_end_i);
          end
        end
      end
      pending_o = expected_runs.size();
    end
  end

endmodule

// ===== test/marker_word_rle_decoder_tb.sv =====
// Testbench top for the marker-word run-length decoder: clock, reset, stimulus, verdict.
// Directed marker cases, then random well-formed streams with noise, bursty sender, stalls.
// Depends on mwrle_pkg, marker_word_rle_decoder and mwrle_run_checker.
`timescale 1ns / 1ps

module marker_word_rle_decoder_tb;
  import mwrle_pkg::*;

  localparam int RandomWords = 600;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 10;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [WordW-1:0] code_word;
  logic             out_valid;
  logic             out_ready;
  logic [WordW-1:0] run_value;
  logic [LenW-1:0]  run_length;
  logic             stream_end;
  int               fail_count;
  int               pending_runs;

  int               words_sent;
  int               burst_left;
  bit               steady_sender;

  marker_word_rle_decoder i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .code_word_i  (code_word),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .run_value_o  (run_value),
    .run_length_o (run_length),
    .stream_end_o (stream_end)
  );

  mwrle_run_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .code_word_i  (code_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .run_value_i  (run_value),
    .run_length_i (run_length),
    .stream_end_i (stream_end),
    .fail_count_o (fail_count),
    .pending_o    (pending_runs)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One input transaction; sender runs in bursts with random gaps between them
  task automatic send_word(input logic [WordW-1:0] w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    code_word <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Count word, biased toward zero, full scale, markers and small runs
  function automatic logic [WordW-1:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return ZeroMark;
      3:       return FillMark;
      4, 5:    return 16'($urandom_range(1, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Non-marker word, sometimes right next to a marker
  function automatic logic [WordW-1:0] pick_literal();
    logic [WordW-1:0] w;
    case ($urandom_range(0, 7))
      0:       w = ZeroMark ^ 16'($urandom_range(1, 255));
      1:       w = FillMark ^ 16'($urandom_range(1, 255));
      2:       w = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      default: w = 16'($urandom);
    endcase
    if (w == ZeroMark || w == FillMark) w = w ^ 16'h0001;
    return w;
  endfunction

  // Receiver: ready pattern that changes mode after each random span
  initial begin : receiver
    int mode;
    int span;
    int stall;
    int tick;
    stall = 0;
    tick  = 0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= (tick % 3 != 0);
          default: begin
            if (stall > 0) begin
              stall--;
              out_ready <= 1'b0;
            end else begin
              out_ready <= 1'b1;
              stall = $urandom_range(4, 20);
            end
          end
        endcase
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stimulus
    int next_toggle;
    in_valid      = 1'b0;
    code_word     = '0;
    out_ready     = 1'b0;
    rst_n         = 1'b0;
    words_sent    = 0;
    burst_left    = 0;
    steady_sender = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: plain extremes, zero counts, full-scale counts, marker counts
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h1235);
    send_word(ZeroMark); send_word(16'h0000);
    send_word(FillMark); send_word(16'h0000);
    send_word(ZeroMark); send_word(16'hFFFF);
    send_word(FillMark); send_word(16'hFFFF);
    send_word(FillMark); send_word(ZeroMark);
    send_word(ZeroMark); send_word(FillMark);
    // pending zero run followed by a literal, then by a fill marker
    send_word(ZeroMark); send_word(ZeroMark); send_word(16'hABCD);
    send_word(ZeroMark); send_word(ZeroMark); send_word(FillMark); send_word(16'h0003);
    // end of stream
    send_word(ZeroMark); send_word(ZeroMark); send_word(ZeroMark);

    // Random: mostly well-formed sequences, some noise
    next_toggle = words_sent + $urandom_range(40, 120);
    while (words_sent < RandomWords) begin
      if (words_sent >= next_toggle) begin
        steady_sender = !steady_sender;
        next_toggle   = words_sent + $urandom_range(40, 120);
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: send_word(pick_literal());
        6, 7, 8: begin
          send_word(ZeroMark);
          send_word(pick_count());
        end
        9, 10, 11: begin
          send_word(FillMark);
          send_word(pick_count());
        end
        12, 13: begin
          send_word(ZeroMark); send_word(ZeroMark); send_word(ZeroMark);
        end
        14, 15: begin
          send_word(ZeroMark);
          send_word(ZeroMark);
          if ($urandom_range(0, 2) == 0) begin
            send_word(FillMark);
            send_word(pick_count());
          end else begin
            send_word(pick_literal());
          end
        end
        16, 17: send_word(16'($urandom));
        default: begin
          // marker-heavy noise
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 2))
              0:       send_word(ZeroMark);
              1:       send_word(FillMark);
              default: send_word(16'($urandom));
            endcase
          end
        end
      endcase
    end
    in_valid <= 1'b0;

    while (pending_runs != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (fail_count == 0 && pending_runs == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
